// ===== hdl/mft_pkg.sv =====
// Shared types and constants for the Manchester frame transmitter.
`timescale 1ns / 1ps

package mft_pkg;

   // Payload field widths
   localparam int CODE_W       = 32;
   localparam int REPEAT_W     = 10;
   localparam int TICK_W       = 16;
   localparam int CSR_INDEX_W  = 2;

   // req_tdata: frame_code then repeat_count, padded to whole bytes
   localparam int REQ_FIELDS_W = CODE_W + REPEAT_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;

   // rsp_tdata: four flags, padded to one byte
   localparam int RSP_FIELDS_W = 4;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Bit positions inside rsp_tdata
   localparam int RSP_LINE_LEVEL    = 0;
   localparam int RSP_BUSY          = 1;
   localparam int RSP_FRAME_END     = 2;
   localparam int RSP_LOAD_REJECTED = 3;

   // Request kinds carried on req_tuser
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_TICKS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_BIT_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS      = 2'd2;

   // Register reset values
   localparam logic [TICK_W-1:0] HEADER_TICKS_RST   = 16'd600;
   localparam logic [TICK_W-1:0] HALF_BIT_TICKS_RST = 16'd300;
   localparam logic [TICK_W-1:0] GAP_TICKS_RST      = 16'd4000;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_BITS   = 4'b0100,
      PH_GAP    = 4'b1000
   } phase_type;

   // Result beat, high bit first in rsp_tdata
   typedef struct packed {
      logic load_rejected;
      logic frame_end;
      logic busy_res;
      logic line_level;
   } rsp_type;

endpackage

// ===== hdl/manchester_frame_transmitter.sv =====
// Manchester frame transmitter: tick-driven frame sequencer with skid-buffered result.
`timescale 1ns / 1ps
//
// Usage
//   req channel: each beat is a tick (req_tuser = 0) that advances the line by
//   one time unit, or a load (req_tuser = 1) carrying frame_code and
//   repeat_count. A load while idle starts repeat_count frames; a load while
//   busy is dropped and flagged as load_rejected. Each frame is a high header,
//   FRAME_BITS Manchester bits MSB first (1 = high/low, 0 = low/high), then a
//   low gap. Durations come from the csr registers and may change any time.
//   rsp channel: exactly one result beat per request beat, in order.
//   Results are registered.
//   Throughput: one request beat per clock while req_tready is high; the state
//   update is a single compare and increment on the 16-bit tick counter per cycle.
//   Stall: the result register plus a one-entry skid buffer let a request be
//   taken while a result waits; req_tready drops only when both are full.
//   Reset: synchronous, active high; line low, idle, registers at defaults
//   (600 / 300 / 4000 ticks), result channel empty.
//   csr channel: always ready; index 3 is ignored.

module manchester_frame_transmitter #(
   parameter int FRAME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [31:0] frame_code, [41:32] repeat_count, rest zero
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mft_pkg::REQ_TDATA_W-1:0]       req_tdata,
   // req_tuser: [0] req_type
   input  logic                                  req_tuser,
   // rsp_tdata: [0] line_level, [1] busy_res, [2] frame_end, [3] load_rejected
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mft_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mft_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mft_pkg::TICK_W-1:0]            csr_data
);
   import mft_pkg::*;

   localparam int BIT_POS_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
   localparam logic [BIT_POS_W-1:0] LAST_BIT = BIT_POS_W'(FRAME_BITS - 1);

   // Configuration
   logic [TICK_W-1:0] header_ticks_ff, half_bit_ticks_ff, gap_ticks_ff;

   // Sequencer state
   phase_type               phase_ff, phase_in;
   logic [TICK_W-1:0]       tick_count_ff, tick_count_in;
   logic [BIT_POS_W-1:0]    bit_position_ff, bit_position_in;
   logic                    second_half_ff, second_half_in;
   logic [FRAME_BITS-1:0]   shift_word_ff, shift_word_in;
   logic [FRAME_BITS-1:0]   held_code_ff, held_code_in;
   logic [REPEAT_W-1:0]     frames_left_ff, frames_left_in;
   logic                    level_ff, level_in;

   // Result register and skid entry
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_data_ff, skid_data_ff;
   rsp_type result;

   logic                  req_take, rsp_take;
   logic [CODE_W-1:0]     req_code;
   logic [REPEAT_W-1:0]   req_repeat;
   logic                  cur_bit;
   logic [TICK_W-1:0]     span_limit;
   logic                  span_done;

   assign req_code   = req_tdata[CODE_W-1:0];
   assign req_repeat = req_tdata[CODE_W +: REPEAT_W];

   assign req_tready = !skid_valid_ff;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_take   = out_valid_ff && rsp_tready;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}}, out_data_ff};
   assign csr_ready  = 1'b1;

   assign cur_bit = shift_word_ff[FRAME_BITS-1];

   // Limit of the current span; a zero limit ends the span on its first tick
   always_comb begin
      case (phase_ff)
         PH_HEADER: span_limit = header_ticks_ff;
         PH_BITS:   span_limit = half_bit_ticks_ff;
         PH_GAP:    span_limit = gap_ticks_ff;
         default:   span_limit = gap_ticks_ff;
      endcase
   end

   assign span_done = ({1'b0, tick_count_ff} + 17'd1) >= {1'b0, span_limit};

   // Next state and result for the accepted beat
   always_comb begin
      phase_in        = phase_ff;
      tick_count_in   = tick_count_ff;
      bit_position_in = bit_position_ff;
      second_half_in  = second_half_ff;
      shift_word_in   = shift_word_ff;
      held_code_in    = held_code_ff;
      frames_left_in  = frames_left_ff;
      level_in        = level_ff;
      result          = '0;

      if (req_tuser == REQ_LOAD) begin
         if (phase_ff != PH_IDLE) begin
            result.load_rejected = 1'b1;
         end else if (req_repeat != '0) begin
            held_code_in    = FRAME_BITS'(req_code);
            shift_word_in   = FRAME_BITS'(req_code);
            frames_left_in  = req_repeat;
            phase_in        = PH_HEADER;
            tick_count_in   = '0;
            bit_position_in = '0;
            second_half_in  = 1'b0;
         end
      end else begin
         case (phase_ff)
            PH_HEADER: begin
               level_in = 1'b1;
               if (span_done) begin
                  tick_count_in   = '0;
                  bit_position_in = '0;
                  second_half_in  = 1'b0;
                  phase_in        = PH_BITS;
               end else begin
                  tick_count_in = tick_count_ff + 16'd1;
               end
            end
            PH_BITS: begin
               level_in = second_half_ff ? !cur_bit : cur_bit;
               if (span_done) begin
                  tick_count_in = '0;
                  if (!second_half_ff) begin
                     second_half_in = 1'b1;
                  end else begin
                     second_half_in = 1'b0;
                     shift_word_in  = {shift_word_ff[FRAME_BITS-2:0], 1'b0};
                     if (bit_position_ff == LAST_BIT) begin
                        bit_position_in = '0;
                        phase_in        = PH_GAP;
                     end else begin
                        bit_position_in = bit_position_ff + 1'b1;
                     end
                  end
               end else begin
                  tick_count_in = tick_count_ff + 16'd1;
               end
            end
            PH_GAP: begin
               level_in = 1'b0;
               if (span_done) begin
                  result.frame_end = 1'b1;
                  tick_count_in    = '0;
                  frames_left_in   = frames_left_ff - 1'b1;
                  if (frames_left_ff == REPEAT_W'(1)) begin
                     phase_in = PH_IDLE;
                  end else begin
                     // next repeat of the same frame
                     phase_in        = PH_HEADER;
                     bit_position_in = '0;
                     second_half_in  = 1'b0;
                     shift_word_in   = held_code_ff;
                  end
               end else begin
                  tick_count_in = tick_count_ff + 16'd1;
               end
            end
            default: begin
               level_in = 1'b0;
            end
         endcase
      end

      result.line_level = level_in;
      result.busy_res   = (phase_in != PH_IDLE);
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ticks_ff   <= HEADER_TICKS_RST;
         half_bit_ticks_ff <= HALF_BIT_TICKS_RST;
         gap_ticks_ff      <= GAP_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEADER_TICKS:   header_ticks_ff   <= csr_data;
            CSR_HALF_BIT_TICKS: half_bit_ticks_ff <= csr_data;
            CSR_GAP_TICKS:      gap_ticks_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tick_count_ff   <= '0;
         bit_position_ff <= '0;
         second_half_ff  <= 1'b0;
         shift_word_ff   <= '0;
         held_code_ff    <= '0;
         frames_left_ff  <= '0;
         level_ff        <= 1'b0;
      end else if (req_take) begin
         phase_ff        <= phase_in;
         tick_count_ff   <= tick_count_in;
         bit_position_ff <= bit_position_in;
         second_half_ff  <= second_half_in;
         shift_word_ff   <= shift_word_in;
         held_code_ff    <= held_code_in;
         frames_left_ff  <= frames_left_in;
         level_ff        <= level_in;
      end
   end

   // Result register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= req_take;
         end
      end else if (req_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_take) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end
      if (out_valid_ff && !rsp_take && req_take) begin
         skid_data_ff <= result;
      end
   end

endmodule

// ===== hdl/mft_checker.sv =====
// Port-level checks for the Manchester frame transmitter, bound to the top level.
`timescale 1ns / 1ps

module mft_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [mft_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import mft_pkg::*;

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // Only ticks end frames, only loads get rejected: never both in one beat
   a_end_or_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[RSP_FRAME_END] && rsp_tdata[RSP_LOAD_REJECTED]))
      else $error("frame_end and load_rejected in one beat");

   // Frame ends in the low gap
   a_end_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_FRAME_END] |-> !rsp_tdata[RSP_LINE_LEVEL])
      else $error("frame_end with line high");

   // Idle line is low
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_BUSY] |-> !rsp_tdata[RSP_LINE_LEVEL])
      else $error("line high while idle");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind manchester_frame_transmitter mft_checker u_mft_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
